/* sv/sha_pkg.sv */
`default_nettype none
package sha_pkg;

   localparam int WordWidth = 32;
   localparam int BufDepth  = 16;
   localparam int BufAddrW  = 4;
   localparam int ChainDepth = 8;
   localparam int ChainAddrW = 3;
   localparam int Rounds = 64;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [2:0] LastWord256 = 3'd7;
   localparam logic [2:0] LastWord224 = 3'd6;

   typedef logic [WordWidth-1:0] word_type;

   function automatic word_type round_k(input logic [5:0] i);
      word_type k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic mode, input logic [2:0] i);
      word_type h;
      case ({mode, i})
         4'd0: h = 32'h6a09e667;  4'd1: h = 32'hbb67ae85;
         4'd2: h = 32'h3c6ef372;  4'd3: h = 32'ha54ff53a;
         4'd4: h = 32'h510e527f;  4'd5: h = 32'h9b05688c;
         4'd6: h = 32'h1f83d9ab;  4'd7: h = 32'h5be0cd19;
         4'd8: h = 32'hc1059ed8;  4'd9: h = 32'h367cd507;
         4'd10: h = 32'h3070dd17; 4'd11: h = 32'hf70e5939;
         4'd12: h = 32'hffc00b31; 4'd13: h = 32'h68581511;
         4'd14: h = 32'h64f98fa7; default: h = 32'hbefa4fa4;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   // round control handed from the sequencer to the round datapath
   typedef struct packed {
      logic       init;     // load working vars from chain words
      logic       round;    // run one round
      logic [5:0] rnd;      // round number
      logic       sched_ld; // w window takes buffer word (rounds 0..15)
   } round_ctl_type;

endpackage
`default_nettype wire

/* sv/sha_stream_if.sv */
`default_nettype none
interface sha_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] msg_word;
   logic [2:0]  valid_bytes;
   logic        end_of_message;
   modport source (output valid, msg_word, valid_bytes, end_of_message, input ready);
   modport sink (input valid, msg_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_digest_word;
   modport source (output valid, digest_word, word_index, last_digest_word, input ready);
   modport sink (input valid, digest_word, word_index, last_digest_word, output ready);
endinterface

interface sha_csr_if;
   logic valid;
   logic ready;
   logic digest_mode;
   modport source (output valid, digest_mode, input ready);
   modport sink (input valid, digest_mode, output ready);
endinterface
`default_nettype wire

/* sv/sha256_224_hash.sv */
`default_nettype none
// A word is accepted in idle and packed into the block byte by byte; no new word is taken
// until it is absorbed and the block returns to idle. A full block is compressed: the
// chain words load the working vars, the rounds run, then the vars are added back. End
// of message adds the pad bytes and one or two compressions, then a read and 7 or 8
// digest transactions, one per cycle while rsp.ready is held, then the chain words are
// reloaded. Throughput is set by byte-serial packing and the single round unit.
// Reset (synchronous): SHA-256 mode, fill and bit count cleared, chain words loaded.
module sha256_224_hash (
   input wire logic clock,
   input wire logic reset,
   sha_req_if.sink  req,
   sha_rsp_if.source rsp,
   sha_csr_if.sink  csr
);
   import sha_pkg::*;

   typedef enum logic [3:0] {
      S_IVLOAD, S_IDLE, S_ABSORB, S_PAD, S_CINIT, S_CROUND, S_CADD, S_OUT
   } state_type;

   state_type    state_ff;
   logic         mode_ff;
   logic [5:0]   fill_ff;      // bytes in block
   logic [63:0]  bits_ff;
   logic [63:0]  len_ff;       // latched length for padding
   word_type     word_ff;
   logic [2:0]   nbytes_ff;    // remaining bytes of held word
   logic         eom_ff;
   logic         padding_ff;   // in padding sequence
   logic         pad80_ff;     // 0x80 already placed
   logic [6:0]   cnt_ff;       // generic step counter
   logic [1:0]   padphase_ff;  // 0 pad and zero bytes, 1 length bytes
   word_type     part_ff;      // word being assembled
   logic         out_v_ff;
   word_type     out_d_ff;
   logic [2:0]   out_i_ff;
   logic         out_l_ff;

   // buffer memory
   logic         buf_we;
   logic [3:0]   buf_wa, buf_ra;
   word_type     buf_wd, buf_rd;
   sha_ram #(.Width(WordWidth), .Depth(BufDepth)) u_buf (
      .clock, .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_addr(buf_ra), .rd_data(buf_rd));

   // chain memory
   logic         ch_we;
   logic [2:0]   ch_wa, ch_ra;
   word_type     ch_wd, ch_rd;
   sha_ram #(.Width(WordWidth), .Depth(ChainDepth)) u_chain (
      .clock, .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
      .rd_addr(ch_ra), .rd_data(ch_rd));

   round_ctl_type ctl;
   word_type      var_out;
   sha_round u_round (.clock, .ctl, .buf_word(buf_rd), .init_word(ch_rd), .var_out);

   // byte placed into assembling word
   logic [7:0] byte_v;
   logic [1:0] bpos;
   word_type   part_next;
   always_comb begin
      bpos = fill_ff[1:0];
      part_next = part_ff;
      part_next[8*(3-bpos) +: 8] = byte_v;
   end

   logic [2:0] last_idx;
   assign last_idx = mode_ff ? LastWord224 : LastWord256;

   assign req.ready = (state_ff == S_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.digest_word = out_d_ff;
   assign rsp.word_index = out_i_ff;
   assign rsp.last_digest_word = out_l_ff;

   // memory control
   always_comb begin
      byte_v = word_ff[31:24];
      if (state_ff == S_PAD) begin
         byte_v = (padphase_ff == 2'd0) ? (pad80_ff ? 8'h00 : PadByte)
                : len_ff[63:56];
      end
      buf_we = 1'b0;
      buf_wa = fill_ff[5:2];
      buf_wd = part_next;
      if ((state_ff == S_ABSORB && nbytes_ff != 3'd0) || state_ff == S_PAD) begin
         buf_we = (bpos == 2'd3);
      end
      buf_ra = cnt_ff[3:0];
      ch_we = 1'b0;
      ch_wa = cnt_ff[2:0];
      ch_wd = init_hash(mode_ff, cnt_ff[2:0]);
      ch_ra = cnt_ff[2:0];
      if (state_ff == S_IVLOAD) begin
         ch_we = 1'b1;
      end else if (state_ff == S_CADD && cnt_ff >= 7'd1 && cnt_ff <= 7'd8) begin
         ch_we = 1'b1;
         ch_wa = 3'(cnt_ff - 7'd1);
         ch_wd = ch_rd + var_out;
      end
      ctl.init = (state_ff == S_CINIT && cnt_ff >= 7'd1)
              || (state_ff == S_CADD && cnt_ff >= 7'd1);
      ctl.round = (state_ff == S_CROUND);
      ctl.rnd = cnt_ff[5:0];
      ctl.sched_ld = (cnt_ff < 7'd16);
      if (state_ff == S_CROUND) begin
         buf_ra = 4'(cnt_ff + 7'd1);
      end else if (state_ff == S_CINIT) begin
         buf_ra = 4'd0;
      end
      if (state_ff == S_OUT) begin
         // read the word the output register takes next; repeat it while stalled
         ch_ra = (!out_v_ff || rsp.ready) ? cnt_ff[2:0] : 3'(cnt_ff - 7'd1);
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IVLOAD;
         mode_ff <= 1'b0;
         fill_ff <= '0;
         bits_ff <= '0;
         cnt_ff <= '0;
         out_v_ff <= 1'b0;
         padding_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IVLOAD: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (csr.valid) begin
                  mode_ff <= csr.digest_mode;
                  fill_ff <= '0;
                  bits_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_IVLOAD;
               end else if (req.valid) begin
                  word_ff <= req.msg_word;
                  nbytes_ff <= (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
                  eom_ff <= req.end_of_message;
                  state_ff <= S_ABSORB;
               end
            end
            S_ABSORB: begin
               if (nbytes_ff != 3'd0) begin
                  part_ff <= part_next;
                  word_ff <= {word_ff[23:0], 8'h00};
                  nbytes_ff <= nbytes_ff - 3'd1;
                  bits_ff <= bits_ff + 64'd8;
                  fill_ff <= fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     cnt_ff <= '0;
                     state_ff <= S_CINIT;
                  end
               end else if (eom_ff) begin
                  len_ff <= bits_ff;
                  padding_ff <= 1'b1;
                  pad80_ff <= 1'b0;
                  padphase_ff <= 2'd0;
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PAD: begin
               part_ff <= part_next;
               fill_ff <= fill_ff + 6'd1;
               if (padphase_ff == 2'd0) begin
                  pad80_ff <= 1'b1;
                  if (fill_ff == 6'd55) begin
                     padphase_ff <= 2'd1;
                  end
               end else begin
                  len_ff <= {len_ff[55:0], 8'h00};
               end
               if (fill_ff == 6'd63) begin
                  cnt_ff <= '0;
                  state_ff <= S_CINIT;
               end
            end
            S_CINIT: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd8) begin
                  cnt_ff <= '0;
                  state_ff <= S_CROUND;
               end
            end
            S_CROUND: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) begin
                  cnt_ff <= '0;
                  state_ff <= S_CADD;
               end
            end
            S_CADD: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd9) begin
                  cnt_ff <= '0;
                  if (!padding_ff) begin
                     state_ff <= S_ABSORB;
                  end else if (padphase_ff == 2'd0) begin
                     state_ff <= S_PAD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               // cnt is the index of the next word loaded plus one
               if (!out_v_ff || rsp.ready) begin
                  if (out_v_ff && out_l_ff) begin
                     out_v_ff <= 1'b0;
                     padding_ff <= 1'b0;
                     fill_ff <= '0;
                     bits_ff <= '0;
                     cnt_ff <= '0;
                     state_ff <= S_IVLOAD;
                  end else if (cnt_ff == 7'd0 && !out_v_ff) begin
                     cnt_ff <= 7'd1;  // first read issued at cnt 0
                  end else begin
                     out_v_ff <= 1'b1;
                     out_d_ff <= ch_rd;
                     out_i_ff <= 3'(cnt_ff - 7'd1);
                     out_l_ff <= (3'(cnt_ff - 7'd1) == last_idx);
                     cnt_ff <= cnt_ff + 7'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* sv/sha_ram.sv */
`default_nettype none
module sha_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/sha_round.sv */
`default_nettype none
// Round datapath: working variables and a 16-word message schedule window.
module sha_round (
   input  wire logic                 clock,
   input  wire sha_pkg::round_ctl_type ctl,
   input  wire sha_pkg::word_type    buf_word,   // block word for rounds 0..15
   input  wire sha_pkg::word_type    init_word,  // chain word shifted in during init
   output sha_pkg::word_type         var_out     // working var leaving (a position)
);
   import sha_pkg::*;

   word_type v_ff [8];
   word_type v_in [8];
   word_type w_ff [16];
   word_type w_in [16];
   word_type wt, s0, s1, ch, mj, t1, e0, e1, wn;

   // schedule: new word from the window
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      wt = ctl.sched_ld ? buf_word : wn;
      for (int i = 0; i < 15; i++) begin
         w_in[i] = w_ff[i+1];
      end
      w_in[15] = wt;
   end

   // compression round
   always_comb begin
      e1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + e1 + ch + round_k(ctl.rnd) + wt;
      e0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
      end
      if (ctl.round) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + e0 + mj;
      end else if (ctl.init) begin
         // rotate: chain word k enters at h, after 8 shifts v[k] = H[k]
         for (int i = 0; i < 7; i++) begin
            v_in[i] = v_ff[i+1];
         end
         v_in[7] = init_word;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (ctl.round) begin
         w_ff <= w_in;
      end
   end

   // during final add the vars rotate the same way, v[0] leaves first
   assign var_out = v_ff[0];
endmodule
`default_nettype wire

/* sv/sha256_224_hash_check.sv */
`default_nettype none
module sha256_224_hash_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_word_index,
   input wire logic       rsp_last_digest_word,
   input wire logic       req_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("rsp dropped while stalled");
   a_no_req_during_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req accepted during digest");
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_digest_word |=> ##1
      (!rsp_valid || rsp_word_index != 3'd0))
      else $error("digest index restarted");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digest_word |->
      (rsp_word_index == 3'd6 || rsp_word_index == 3'd7))
      else $error("bad last index");
endmodule

bind sha256_224_hash sha256_224_hash_check u_check (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_last_digest_word(rsp.last_digest_word),
   .req_ready(req.ready));
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import sha_pkg::*;

   typedef struct {
      logic [31:0] msg_word;
      logic [2:0]  valid_bytes;
      logic        end_of_message;
      bit          is_mode_write; // pseudo-item: mode write once idle
      logic        mode;
      bit          drain;         // pseudo-item: hold until results are in
   } msg_txn_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_digest_word;
   } digest_txn_type;

   localparam int StallLimit = 20000;
   localparam int SettleCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha_req_if req();
   sha_rsp_if rsp();
   sha_csr_if csr();

   sha256_224_hash dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // predictor state
   logic        pred_mode;
   logic [31:0] pred_chain[8];
   logic [31:0] pred_block[16];
   int unsigned pred_fill;
   logic [63:0] pred_bits;

   msg_txn_type    pending_msgs[$];
   digest_txn_type expected_digests[$];
   int             fail_count = 0;
   bit             calm_phase = 1'b0; // no idling near the end
   bit             stim_done = 1'b0;

   // append one pending item at the tail
   task automatic queue_item(input msg_txn_type t);
      pending_msgs = {pending_msgs, t};
   endtask

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] start_hash(input logic m, input int i);
      logic [31:0] h256[8];
      logic [31:0] h224[8];
      h256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      h224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
               32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
      return m ? h224[i] : h256[i];
   endfunction

   task automatic restart_chain();
      for (int i = 0; i < 8; i++) pred_chain[i] = start_hash(pred_mode, i);
      pred_fill = 0;
      pred_bits = '0;
   endtask

   task automatic compress_block();
      logic [31:0] kc[64];
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] s0, s1, t1, ch, mj;
      kc = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++) w[i] = pred_block[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = pred_chain;
      for (int i = 0; i < 64; i++) begin
         s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + kc[i] + w[i];
         s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
         v[0] = t1 + s0 + mj;
      end
      for (int i = 0; i < 8; i++) pred_chain[i] += v[i];
   endtask

   task automatic append_byte(input logic [7:0] b);
      int sh;
      sh = 24 - 8 * (pred_fill % 4);
      pred_block[pred_fill / 4] = (pred_block[pred_fill / 4] & ~(32'hff << sh))
                                  | (32'(b) << sh);
      pred_fill++;
      if (pred_fill == 64) begin
         compress_block();
         pred_fill = 0;
      end
   endtask

   // expected digest words for one accepted message transaction
   task automatic predict_digest(input msg_txn_type t);
      int nb, nw;
      logic [63:0] len;
      digest_txn_type d;
      nb = (t.valid_bytes > 4) ? 4 : t.valid_bytes;
      for (int i = 0; i < nb; i++) begin
         append_byte(t.msg_word[31 - 8*i -: 8]);
         pred_bits += 64'd8;
      end
      if (!t.end_of_message) return;
      len = pred_bits;
      append_byte(PadByte);
      while (pred_fill != 56) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
      nw = pred_mode ? 7 : 8;
      for (int k = 0; k < nw; k++) begin
         d.digest_word = pred_chain[k];
         d.word_index = 3'(k);
         d.last_digest_word = (k == nw - 1);
         expected_digests = {expected_digests, d};
      end
      restart_chain();
   endtask

   // stimulus builders
   function automatic msg_txn_type word_txn(input logic [31:0] w, input logic [2:0] n,
                                            input logic e);
      msg_txn_type t;
      t = '{msg_word: w, valid_bytes: n, end_of_message: e,
            is_mode_write: 0, mode: 0, drain: 0};
      return t;
   endfunction

   task automatic add_mode_write(input logic m);
      msg_txn_type t;
      t = word_txn('0, '0, 0);
      t.is_mode_write = 1;
      t.mode = m;
      queue_item(t);
   endtask

   task automatic add_drain();
      msg_txn_type t;
      t = word_txn('0, '0, 0);
      t.drain = 1;
      queue_item(t);
   endtask

   // well-formed message with random content, sometimes with noise words
   task automatic add_message(input int nwords);
      logic [2:0] n;
      for (int i = 0; i < nwords; i++) begin
         n = 3'd4;
         if ($urandom_range(0, 9) == 0) n = 3'($urandom_range(0, 7));
         queue_item(word_txn($urandom, n, 0));
      end
      queue_item(word_txn($urandom, 3'($urandom_range(0, 7)), 1));
   endtask

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // driver
   int  req_gap = 0;
   int  csr_wait = 0;
   bit  in_mode_write = 0;
   initial begin
      req.valid = 0; req.msg_word = '0; req.valid_bytes = '0; req.end_of_message = 0;
      csr.valid = 0; csr.digest_mode = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         csr.valid <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            pred_mode = csr.digest_mode;
            restart_chain();
            csr.valid <= 0;
            void'(pending_msgs.pop_front());
            in_mode_write = 0;
         end
         if (req.valid && req.ready) begin
            predict_digest(pending_msgs.pop_front());
            if (!calm_phase && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 9);
         end
         if (!(req.valid && !req.ready) && !in_mode_write) begin
            if (pending_msgs.size() == 0) begin
               req.valid <= 0;
               stim_done = 1;
            end else if (pending_msgs[0].is_mode_write || pending_msgs[0].drain) begin
               req.valid <= 0;
               if (expected_digests.size() == 0 && !(req.valid && !req.ready)) begin
                  if (csr_wait < SettleCycles) csr_wait++;
                  else begin
                     csr_wait = 0;
                     if (pending_msgs[0].drain) void'(pending_msgs.pop_front());
                     else begin
                        csr.valid <= 1;
                        csr.digest_mode <= pending_msgs[0].mode;
                        in_mode_write = 1;
                     end
                  end
               end
            end else if (req_gap > 0) begin
               req.valid <= 0;
               req_gap--;
            end else begin
               req.valid <= 1;
               req.msg_word <= pending_msgs[0].msg_word;
               req.valid_bytes <= pending_msgs[0].valid_bytes;
               req.end_of_message <= pending_msgs[0].end_of_message;
            end
         end
      end
   end

   // monitor with random backpressure
   int rsp_stall = 0;
   initial rsp.ready = 0;
   always @(posedge clock) begin
      digest_txn_type exp_d;
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_digests.size() == 0) begin
               $error("unexpected digest transaction: %h", rsp.digest_word);
               fail_count++;
            end else begin
               exp_d = expected_digests.pop_front();
               if (rsp.digest_word !== exp_d.digest_word) begin
                  $error("digest_word: expected %h, got %h", exp_d.digest_word,
                         rsp.digest_word);
                  fail_count++;
               end
               if (rsp.word_index !== exp_d.word_index) begin
                  $error("word_index: expected %0d, got %0d", exp_d.word_index,
                         rsp.word_index);
                  fail_count++;
               end
               if (rsp.last_digest_word !== exp_d.last_digest_word) begin
                  $error("last_digest_word: expected %0b, got %0b",
                         exp_d.last_digest_word, rsp.last_digest_word);
                  fail_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp.ready <= 0;
            rsp_stall--;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 0;
            rsp_stall = $urandom_range(0, 8);
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   // watchdog on stretches with no accepted transaction
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready)
          || in_mode_write == 0 && csr_wait > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("sha256_224_hash regression: fail");
         $finish;
      end
   end

   initial begin
      int nmsg;
      pred_mode = 0;
      restart_chain();
      for (int i = 0; i < 16; i++) pred_block[i] = '0;

      // directed: empty message, field extremes, short and oversize counts
      queue_item(word_txn(32'h0, 3'd0, 1));
      queue_item(word_txn(32'h61626300, 3'd3, 1));        // "abc"
      queue_item(word_txn(32'hffffffff, 3'd4, 0));
      queue_item(word_txn(32'h00000000, 3'd7, 0));        // treated as 4
      queue_item(word_txn(32'hdeadbeef, 3'd0, 0));        // empty non-last
      queue_item(word_txn(32'h12345678, 3'd1, 0));        // short non-last
      queue_item(word_txn(32'hffffffff, 3'd5, 1));
      // 14 words: pad spills into an extra block
      for (int i = 0; i < 14; i++) queue_item(word_txn(32'haaaa5555, 3'd4, 0));
      queue_item(word_txn(32'h5555aaaa, 3'd6, 1));
      add_mode_write(1);
      queue_item(word_txn(32'h61626300, 3'd3, 1));
      // abandoned message across a mode write
      queue_item(word_txn(32'hcafef00d, 3'd4, 0));
      add_mode_write(0);
      add_drain();

      // random messages, mostly small
      while (pending_msgs.size() < 360) begin
         nmsg = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
         add_message(nmsg);
         if ($urandom_range(0, 11) == 0) add_mode_write(1'($urandom_range(0, 1)));
         if ($urandom_range(0, 15) == 0) add_drain();
      end
      add_mode_write(1);
      add_message(20);
      add_mode_write(0);

      repeat (8) @(posedge clock);
      reset <= 0;

      wait (pending_msgs.size() < 30);
      calm_phase = 1;
      add_message(12);
      wait (stim_done && expected_digests.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && expected_digests.size() == 0)
         $display("sha256_224_hash regression: pass");
      else
         $display("sha256_224_hash regression: fail");
      $finish;
   end
endmodule
